// ----- design/seven_joint_forward_kinematics_top_defines.svh -----
// ----------------------------------------------------------------------------
// seven_joint_forward_kinematics_top_defines
// Assertion helpers for the forward kinematics checker.
// ----------------------------------------------------------------------------
`ifndef SEVEN_JOINT_FORWARD_KINEMATICS_TOP_DEFINES_SVH
`define SEVEN_JOINT_FORWARD_KINEMATICS_TOP_DEFINES_SVH

// Check a property on every rising clock edge, reset included.
`define SJFK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// Check a property outside reset only.
`define SJFK_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`endif

// ----- design/sjfk_pkg.sv -----
// ----------------------------------------------------------------------------
// sjfk_pkg
// Types, constants and helpers shared by the forward kinematics pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sjfk_pkg;

    localparam int NUM_JOINTS     = 7;
    localparam int IFRAC          = 28;
    localparam int CORDIC_STEPS   = 28;
    localparam int SINCOS_STAGES  = CORDIC_STEPS + 2;
    localparam int COMPOSE_STAGES = 2;
    localparam int NUM_COMPOSE    = NUM_JOINTS + 1;
    localparam int PIPE_STAGES    = SINCOS_STAGES + NUM_COMPOSE * COMPOSE_STAGES;
    localparam int POS_FRAC       = 16;
    localparam int POS_WIDTH      = 18;
    localparam int ZW             = 34;

    typedef logic signed [31:0] t_q;
    typedef logic signed [63:0] t_prod;
    typedef t_q [0:2] t_vec;

    typedef struct packed {
        t_q [0:2][0:2] r;
        t_vec          p;
    } t_pose;

    typedef enum logic [1:0] {
        KIND_Z,
        KIND_UP,
        KIND_DOWN
    } t_kind;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    localparam t_q    CORDIC_GAIN = 32'sd163008218;
    localparam t_prod PHASE_K     = 64'sd5468522205;
    localparam t_q    ONE_Q       = 32'sd268435456;
    localparam t_q    OFF_D1      = 32'sd89389007;
    localparam t_q    OFF_D3      = 32'sd84825604;
    localparam t_q    OFF_A4      = 32'sd22145925;
    localparam t_q    OFF_D5      = 32'sd103079215;
    localparam t_q    OFF_A7      = 32'sd23622320;
    localparam t_q    OFF_FL      = 32'sd65766687;
    localparam t_q    HALF_SQRT2  = 32'sd189812531;

    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    localparam t_kind JOINT_KIND [0:NUM_JOINTS-1] = '{
        KIND_Z, KIND_UP, KIND_DOWN, KIND_DOWN, KIND_UP, KIND_DOWN, KIND_DOWN
    };

    localparam t_vec JOINT_OFF [0:NUM_JOINTS-1] = '{
        '{32'sd0, 32'sd0, OFF_D1},
        '{32'sd0, 32'sd0, 32'sd0},
        '{32'sd0, -OFF_D3, 32'sd0},
        '{OFF_A4, 32'sd0, 32'sd0},
        '{-OFF_A4, OFF_D5, 32'sd0},
        '{32'sd0, 32'sd0, 32'sd0},
        '{OFF_A7, 32'sd0, 32'sd0}
    };

    function automatic t_prod mul_q(t_q a, t_q b);
        return 64'(a) * 64'(b);
    endfunction

    // Round half up from a Q56 product sum back to Q28.
    function automatic t_q round_q(t_prod acc);
        t_prod sh;
        sh = (acc + (64'sd1 <<< (IFRAC - 1))) >>> IFRAC;
        return sh[31:0];
    endfunction

    function automatic t_pose identity_pose();
        t_pose m;
        m = '0;
        m.r[0][0] = ONE_Q;
        m.r[1][1] = ONE_Q;
        m.r[2][2] = ONE_Q;
        return m;
    endfunction

    function automatic t_pose flange_pose();
        t_pose m;
        m = '0;
        m.r[0][0] = HALF_SQRT2;
        m.r[0][1] = HALF_SQRT2;
        m.r[1][0] = -HALF_SQRT2;
        m.r[1][1] = HALF_SQRT2;
        m.r[2][2] = ONE_Q;
        m.p[2]    = OFF_FL;
        return m;
    endfunction

    function automatic t_pose build_joint(t_kind kind, t_q c, t_q s, t_vec off);
        t_pose m;
        m = '0;
        m.r[0][0] = c;
        m.r[0][1] = -s;
        case (kind)
            KIND_Z: begin
                m.r[1][0] = s;
                m.r[1][1] = c;
                m.r[2][2] = ONE_Q;
            end
            KIND_UP: begin
                m.r[1][2] = ONE_Q;
                m.r[2][0] = -s;
                m.r[2][1] = -c;
            end
            default: begin
                m.r[1][2] = -ONE_Q;
                m.r[2][0] = s;
                m.r[2][1] = c;
            end
        endcase
        m.p = off;
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- design/sjfk_joint_if.sv -----
// ----------------------------------------------------------------------------
// sjfk_joint_if
// Channel carrying one set of seven joint angles.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjfk_joint_if #(
    parameter int ANGLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] joint1_angle;
    logic signed [ANGLE_WIDTH-1:0] joint2_angle;
    logic signed [ANGLE_WIDTH-1:0] joint3_angle;
    logic signed [ANGLE_WIDTH-1:0] joint4_angle;
    logic signed [ANGLE_WIDTH-1:0] joint5_angle;
    logic signed [ANGLE_WIDTH-1:0] joint6_angle;
    logic signed [ANGLE_WIDTH-1:0] joint7_angle;

    modport source (
        output valid, joint1_angle, joint2_angle, joint3_angle, joint4_angle,
               joint5_angle, joint6_angle, joint7_angle,
        input  ready
    );
    modport sink (
        input  valid, joint1_angle, joint2_angle, joint3_angle, joint4_angle,
               joint5_angle, joint6_angle, joint7_angle,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/sjfk_pose_if.sv -----
// ----------------------------------------------------------------------------
// sjfk_pose_if
// Channel carrying one end-effector pose: rotation and translation.
// ----------------------------------------------------------------------------
`default_nettype none

interface sjfk_pose_if #(
    parameter int OUT_FRAC_BITS = 14
);
    localparam int RW = OUT_FRAC_BITS + 2;
    localparam int PW = 18;

    logic                 valid;
    logic                 ready;
    logic signed [RW-1:0] rot_r0c0;
    logic signed [RW-1:0] rot_r0c1;
    logic signed [RW-1:0] rot_r0c2;
    logic signed [RW-1:0] rot_r1c0;
    logic signed [RW-1:0] rot_r1c1;
    logic signed [RW-1:0] rot_r1c2;
    logic signed [RW-1:0] rot_r2c0;
    logic signed [RW-1:0] rot_r2c1;
    logic signed [RW-1:0] rot_r2c2;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_z;

    modport source (
        output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
               rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
               rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/seven_joint_forward_kinematics_top.sv -----
// ----------------------------------------------------------------------------
// seven_joint_forward_kinematics_top
// Seven-joint arm forward kinematics, one pose per set of joint angles.
// ----------------------------------------------------------------------------
// Usage:
//   i_joint carries seven signed Q3.13 joint angles; o_pose returns the 3x3
//   rotation (units of 2^-OUT_FRAC_BITS, saturated to +/-1) and the
//   translation (units of 2^-16 m, saturated to 18 bits).
//   Throughput: one transfer per cycle unless the pipeline is frozen. Seven
//   sine/cosine lanes run side by side; a chain of eight two-stage pose
//   products merges their results. Data passes the lanes, the product chain
//   and the output round/saturate register on its way to o_pose.valid.
//   Backpressure: when o_pose holds a result that is not taken and the last
//   pipeline stage is also full, the whole pipeline freezes and i_joint.ready
//   drops; otherwise new transfers keep flowing into empty stages.
//   Reset (synchronous, active low) drops every item in flight and clears
//   o_pose.valid; data registers keep their contents but are not marked valid.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_joint_forward_kinematics_top #(
    parameter int ANGLE_WIDTH   = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sjfk_joint_if.sink   i_joint,
    sjfk_pose_if.source  o_pose
);
    import sjfk_pkg::*;

    localparam int ROT_WIDTH = OUT_FRAC_BITS + 2;
    localparam int ROT_SH    = IFRAC - OUT_FRAC_BITS;
    localparam int POS_SH    = IFRAC - POS_FRAC;
    localparam logic signed [32:0] ROT_ONE = 33'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [32:0] POS_MAX = (33'sd1 <<< (POS_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] POS_MIN = -(33'sd1 <<< (POS_WIDTH - 1));

    logic                          w_adv;
    logic                          w_take;
    logic [PIPE_STAGES-1:0]        r_vld;
    logic [PIPE_STAGES-1:0]        n_vld;
    logic                          r_out_vld;
    logic                          n_out_vld;
    logic signed [ANGLE_WIDTH-1:0] w_angle [0:NUM_JOINTS-1];
    t_q                            w_cos   [0:NUM_JOINTS-1];
    t_q                            w_sin   [0:NUM_JOINTS-1];
    t_pose                         w_b     [0:NUM_COMPOSE-1];
    t_pose                         w_acc   [0:NUM_COMPOSE];
    logic signed [ROT_WIDTH-1:0]   r_rot   [0:2][0:2];
    logic signed [POS_WIDTH-1:0]   r_pos   [0:2];

    // Freeze only when both the output register and the last stage are full and o_pose.ready is low.
    assign w_adv  = !(r_vld[PIPE_STAGES-1] && r_out_vld && !o_pose.ready);
    assign w_take = i_joint.valid && w_adv;
    assign i_joint.ready = w_adv;

    always_comb begin
        n_vld = r_vld;
        if (w_adv) begin
            n_vld = {r_vld[PIPE_STAGES-2:0], w_take};
        end
        n_out_vld = r_out_vld;
        if (w_adv && r_vld[PIPE_STAGES-1]) begin
            n_out_vld = 1'b1;
        end else if (o_pose.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= n_vld;
            r_out_vld <= n_out_vld;
        end
    end

    assign w_angle[0] = i_joint.joint1_angle;
    assign w_angle[1] = i_joint.joint2_angle;
    assign w_angle[2] = i_joint.joint3_angle;
    assign w_angle[3] = i_joint.joint4_angle;
    assign w_angle[4] = i_joint.joint5_angle;
    assign w_angle[5] = i_joint.joint6_angle;
    assign w_angle[6] = i_joint.joint7_angle;

    // Sine/cosine lanes; each joint after the first is delayed in a shift line so it meets its product.
    for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
        t_q w_dc;
        t_q w_ds;

        sjfk_sincos #(
            .ANGLE_WIDTH(ANGLE_WIDTH)
        ) u_sincos (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_angle (w_angle[j]),
            .o_cos   (w_cos[j]),
            .o_sin   (w_sin[j])
        );

        if (j == 0) begin : g_direct
            assign w_dc = w_cos[j];
            assign w_ds = w_sin[j];
        end else begin : g_delay
            localparam int DEPTH = COMPOSE_STAGES * j;
            t_q r_dc [0:DEPTH-1];
            t_q r_ds [0:DEPTH-1];

            // Hold the pair in a shift line, advance with the pipeline.
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dc[0] <= w_cos[j];
                    r_ds[0] <= w_sin[j];
                    for (int d = 1; d < DEPTH; d++) begin
                        r_dc[d] <= r_dc[d-1];
                        r_ds[d] <= r_ds[d-1];
                    end
                end
            end
            assign w_dc = r_dc[DEPTH-1];
            assign w_ds = r_ds[DEPTH-1];
        end

        assign w_b[j] = build_joint(JOINT_KIND[j], w_dc, w_ds, JOINT_OFF[j]);
    end

    assign w_b[NUM_COMPOSE-1] = flange_pose();
    assign w_acc[0] = identity_pose();

    // Merge: chain the joint transforms and the flange from identity.
    for (genvar k = 0; k < NUM_COMPOSE; k++) begin : g_chain
        sjfk_compose u_compose (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (w_acc[k]),
            .i_b   (w_b[k]),
            .o_c   (w_acc[k+1])
        );
    end

    // Output register: round half up to the output scale, then saturate.
    always_ff @(posedge i_clk) begin
        logic signed [32:0] v;
        if (w_adv && r_vld[PIPE_STAGES-1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    v = (33'(w_acc[NUM_COMPOSE].r[i][j]) + (33'sd1 <<< (ROT_SH - 1)))
                        >>> ROT_SH;
                    if (v > ROT_ONE) begin
                        v = ROT_ONE;
                    end else if (v < -ROT_ONE) begin
                        v = -ROT_ONE;
                    end
                    r_rot[i][j] <= v[ROT_WIDTH-1:0];
                end
                v = (33'(w_acc[NUM_COMPOSE].p[i]) + (33'sd1 <<< (POS_SH - 1))) >>> POS_SH;
                if (v > POS_MAX) begin
                    v = POS_MAX;
                end else if (v < POS_MIN) begin
                    v = POS_MIN;
                end
                r_pos[i] <= v[POS_WIDTH-1:0];
            end
        end
    end

    assign o_pose.valid    = r_out_vld;
    assign o_pose.rot_r0c0 = r_rot[0][0];
    assign o_pose.rot_r0c1 = r_rot[0][1];
    assign o_pose.rot_r0c2 = r_rot[0][2];
    assign o_pose.rot_r1c0 = r_rot[1][0];
    assign o_pose.rot_r1c1 = r_rot[1][1];
    assign o_pose.rot_r1c2 = r_rot[1][2];
    assign o_pose.rot_r2c0 = r_rot[2][0];
    assign o_pose.rot_r2c1 = r_rot[2][1];
    assign o_pose.rot_r2c2 = r_rot[2][2];
    assign o_pose.pos_x    = r_pos[0];
    assign o_pose.pos_y    = r_pos[1];
    assign o_pose.pos_z    = r_pos[2];

endmodule

`default_nettype wire

// ----- design/sjfk_sincos.sv -----
// ----------------------------------------------------------------------------
// sjfk_sincos
// One angle lane: phase scaling, pipelined 28-step CORDIC, quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module sjfk_sincos #(
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [ANGLE_WIDTH-1:0] i_angle,
    output sjfk_pkg::t_q                       o_cos,
    output sjfk_pkg::t_q                       o_sin
);
    import sjfk_pkg::*;

    t_prod       w_prod;
    logic [1:0]  r_quad [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS-1];
    t_q          r_x [1:CORDIC_STEPS];
    t_q          r_y [1:CORDIC_STEPS];
    t_q          w_x [0:CORDIC_STEPS-1];
    t_q          w_y [0:CORDIC_STEPS-1];
    t_q          r_cos;
    t_q          r_sin;

    // Angle in 2^-32 turn: bits 47:16 of the rounded product.
    assign w_prod = 64'(i_angle) * PHASE_K + 64'sd32768;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad[0] <= w_prod[47:46];
            r_z[0]    <= ZW'(w_prod[45:16]);
        end
    end

    assign w_x[0] = CORDIC_GAIN;
    assign w_y[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        t_q dx;
        t_q dy;
        if (i > 0) begin : g_tap
            assign w_x[i] = r_x[i];
            assign w_y[i] = r_y[i];
        end
        assign dx = w_y[i] >>> i;
        assign dy = w_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quad[i+1] <= r_quad[i];
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= w_x[i] - dx;
                    r_y[i+1] <= w_y[i] + dy;
                end else begin
                    r_x[i+1] <= w_x[i] + dx;
                    r_y[i+1] <= w_y[i] - dy;
                end
            end
        end

        if (i < CORDIC_STEPS - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[i][ZW-1]) begin
                        r_z[i+1] <= r_z[i] - ZW'(ATAN_TURNS[i]);
                    end else begin
                        r_z[i+1] <= r_z[i] + ZW'(ATAN_TURNS[i]);
                    end
                end
            end
        end
    end

    // Fold the quadrant back in.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (t_quad'(r_quad[CORDIC_STEPS]))
                QUAD_0: begin
                    r_cos <= r_x[CORDIC_STEPS];
                    r_sin <= r_y[CORDIC_STEPS];
                end
                QUAD_1: begin
                    r_cos <= -r_y[CORDIC_STEPS];
                    r_sin <= r_x[CORDIC_STEPS];
                end
                QUAD_2: begin
                    r_cos <= -r_x[CORDIC_STEPS];
                    r_sin <= -r_y[CORDIC_STEPS];
                end
                default: begin
                    r_cos <= r_y[CORDIC_STEPS];
                    r_sin <= -r_x[CORDIC_STEPS];
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

`default_nettype wire

// ----- design/sjfk_compose.sv -----
// ----------------------------------------------------------------------------
// sjfk_compose
// Two-stage pose product C = A*B: multiply, then sum, round and offset.
// ----------------------------------------------------------------------------
`default_nettype none

module sjfk_compose (
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  sjfk_pkg::t_pose i_a,
    input  sjfk_pkg::t_pose i_b,
    output sjfk_pkg::t_pose o_c
);
    import sjfk_pkg::*;

    t_prod r_pr [0:2][0:2][0:2];
    t_prod r_pp [0:2][0:2];
    t_vec  r_ap;
    t_pose w_c;
    t_pose r_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_pr[i][j][k] <= mul_q(i_a.r[i][k], i_b.r[k][j]);
                    end
                    r_pp[i][k] <= mul_q(i_a.r[i][k], i_b.p[k]);
                end
            end
            r_ap <= i_a.p;
        end
    end

    always_comb begin
        w_c = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_c.r[i][j] = round_q(r_pr[i][j][0] + r_pr[i][j][1] + r_pr[i][j][2]);
            end
            w_c.p[i] = round_q(r_pp[i][0] + r_pp[i][1] + r_pp[i][2]) + r_ap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= w_c;
        end
    end

    assign o_c = r_c;

endmodule

`default_nettype wire

// ----- design/sjfk_checker.sv -----
// ----------------------------------------------------------------------------
// sjfk_checker
// Port-level checks of the forward kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seven_joint_forward_kinematics_top_defines.svh"

module sjfk_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);
    // A pending result holds until transferred.
    `SJFK_ASSERT_RUN(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")
    // Reset leaves no result pending.
    `SJFK_ASSERT(a_rst_clear, !i_rst_n |=> !i_out_valid, "valid after reset")
    // Input stalls only under output backpressure.
    `SJFK_ASSERT(a_stall_cause, !i_in_ready |-> i_out_valid && !i_out_ready, "bad stall")

endmodule

bind seven_joint_forward_kinematics_top sjfk_checker u_sjfk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_joint.ready),
    .i_out_valid (o_pose.valid),
    .i_out_ready (o_pose.ready)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the seven-joint forward kinematics pipeline against a bit-exact
// in-bench pose predictor. Joint sets go through a randomly gapped driver.
// Poses are taken by a randomly stalling monitor and compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import sjfk_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int PIPE_DEPTH = 47;
    localparam int ROT_ONE    = 16384;
    localparam int NUM_RANDOM = 1200;

    // One joint set, plus a flag that holds it until the pipeline is empty.
    typedef struct packed {
        logic              drain;
        logic [6:0][15:0]  angle;
    } joint_set_t;

    typedef struct packed {
        logic [8:0][15:0]  rot;
        logic [2:0][17:0]  pos;
    } pose_word_t;

    typedef struct {
        longint r[3][3];
        longint p[3];
    } fk_pose_t;

    logic i_clk;
    logic i_rst_n;

    sjfk_joint_if #(.ANGLE_WIDTH(16))   joint_ch ();
    sjfk_pose_if  #(.OUT_FRAC_BITS(14)) pose_ch ();

    seven_joint_forward_kinematics_top #(
        .ANGLE_WIDTH  (16),
        .OUT_FRAC_BITS(14)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_joint(joint_ch.sink),
        .o_pose (pose_ch.source)
    );

    joint_set_t joint_sets_q[$];
    pose_word_t pending_poses_q[$];
    int         mismatch_count;

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Pose predictor
    // ------------------------------------------------------------------------

    // Rotation-mode CORDIC on the 32-bit turn phase; c and s come back in Q28.
    function automatic void joint_sin_cos(logic [15:0] ang, output longint c,
                                          output longint s);
        bit [63:0] ext;
        bit [63:0] prod;
        bit [31:0] phase;
        longint    x, y, z, dx, dy;
        x = longint'(CORDIC_GAIN);
        y = 0;
        ext   = {{48{ang[15]}}, ang};
        prod  = ext * 64'd5468522205 + 64'd32768;
        phase = prod[47:16];
        z     = longint'({34'd0, phase[29:0]});
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'({32'd0, ATAN_TURNS[i]});
            end else begin
                x += dx; y -= dy; z += longint'({32'd0, ATAN_TURNS[i]});
            end
        end
        case (t_quad'(phase[31:30]))
            QUAD_0:  begin c = x;  s = y;  end
            QUAD_1:  begin c = -y; s = x;  end
            QUAD_2:  begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic longint round_to(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Chain b onto a: rotations multiply, b's offset is rotated and added.
    function automatic fk_pose_t chain_pose(fk_pose_t a, fk_pose_t b);
        fk_pose_t res;
        longint   acc;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += a.r[i][k] * b.r[k][j];
                res.r[i][j] = round_to(acc, IFRAC);
            end
            acc = 0;
            for (int k = 0; k < 3; k++) acc += a.r[i][k] * b.p[k];
            res.p[i] = round_to(acc, IFRAC) + a.p[i];
        end
        return res;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic pose_word_t predict_pose(joint_set_t js);
        fk_pose_t   acc, m;
        longint     c, s, one;
        pose_word_t res;
        one = longint'(ONE_Q);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) acc.r[i][j] = (i == j) ? one : 0;
        acc.p = '{0, 0, 0};
        for (int jn = 0; jn < NUM_JOINTS; jn++) begin
            joint_sin_cos(js.angle[jn], c, s);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) m.r[i][j] = 0;
            m.r[0][0] = c;
            m.r[0][1] = -s;
            case (JOINT_KIND[jn])
                KIND_Z: begin
                    m.r[1][0] = s; m.r[1][1] = c; m.r[2][2] = one;
                end
                KIND_UP: begin
                    m.r[1][2] = one; m.r[2][0] = -s; m.r[2][1] = -c;
                end
                default: begin
                    m.r[1][2] = -one; m.r[2][0] = s; m.r[2][1] = c;
                end
            endcase
            for (int k = 0; k < 3; k++) m.p[k] = longint'(JOINT_OFF[jn][k]);
            acc = chain_pose(acc, m);
        end
        // Flange: 45 degree turn about z and the tool offset.
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) m.r[i][j] = 0;
        m.r[0][0] = longint'(HALF_SQRT2);
        m.r[0][1] = longint'(HALF_SQRT2);
        m.r[1][0] = -longint'(HALF_SQRT2);
        m.r[1][1] = longint'(HALF_SQRT2);
        m.r[2][2] = one;
        m.p = '{0, 0, longint'(OFF_FL)};
        acc = chain_pose(acc, m);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                res.rot[i * 3 + j] = 16'(clip(round_to(acc.r[i][j], IFRAC - 14),
                                              -ROT_ONE, ROT_ONE));
        for (int i = 0; i < 3; i++)
            res.pos[i] = 18'(clip(round_to(acc.p[i], IFRAC - POS_FRAC),
                                  -131072, 131071));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long. A burst mode
    // turns idling off entirely for a stretch.
    // ------------------------------------------------------------------------
    function automatic int pick_gap(bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present joint sets, predict each pose at its transfer.
    // ------------------------------------------------------------------------
    int drv_gap;
    bit drv_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            joint_ch.valid <= 1'b0;
            drv_gap        <= 0;
            drv_burst      <= 1'b0;
        end else begin
            if (joint_ch.valid && joint_ch.ready)
                pending_poses_q.push_back(predict_pose({1'b0,
                    joint_ch.joint7_angle, joint_ch.joint6_angle,
                    joint_ch.joint5_angle, joint_ch.joint4_angle,
                    joint_ch.joint3_angle, joint_ch.joint2_angle,
                    joint_ch.joint1_angle}));
            if ($urandom_range(0, 149) == 0) drv_burst <= ~drv_burst;
            // Hold the current set until it transfers.
            if (!joint_ch.valid || joint_ch.ready) begin
                if (drv_gap > 0) begin
                    drv_gap        <= drv_gap - 1;
                    joint_ch.valid <= 1'b0;
                end else if (joint_sets_q.size() != 0 &&
                             !(joint_sets_q[0].drain &&
                               (pending_poses_q.size() != 0 ||
                                (joint_ch.valid && joint_ch.ready)))) begin
                    joint_set_t js;
                    js = joint_sets_q.pop_front();
                    joint_ch.joint1_angle <= js.angle[0];
                    joint_ch.joint2_angle <= js.angle[1];
                    joint_ch.joint3_angle <= js.angle[2];
                    joint_ch.joint4_angle <= js.angle[3];
                    joint_ch.joint5_angle <= js.angle[4];
                    joint_ch.joint6_angle <= js.angle[5];
                    joint_ch.joint7_angle <= js.angle[6];
                    joint_ch.valid        <= 1'b1;
                    drv_gap               <= pick_gap(drv_burst);
                end else begin
                    joint_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall at random, compare each pose with the oldest prediction.
    // ------------------------------------------------------------------------
    int mon_gap;
    bit mon_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_ch.ready <= 1'b0;
            mon_gap       <= 0;
            mon_burst     <= 1'b0;
        end else begin
            if (pose_ch.valid && pose_ch.ready) begin
                pose_word_t got, want;
                got.rot = {pose_ch.rot_r2c2, pose_ch.rot_r2c1, pose_ch.rot_r2c0,
                           pose_ch.rot_r1c2, pose_ch.rot_r1c1, pose_ch.rot_r1c0,
                           pose_ch.rot_r0c2, pose_ch.rot_r0c1, pose_ch.rot_r0c0};
                got.pos = {pose_ch.pos_z, pose_ch.pos_y, pose_ch.pos_x};
                if (pending_poses_q.size() == 0) begin
                    $error("pose transfer with no prediction pending");
                    mismatch_count++;
                end else begin
                    want = pending_poses_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got.rot[i] !== want.rot[i]) begin
                            $error("rot_r%0dc%0d expected %0d got %0d", i / 3, i % 3,
                                   $signed(want.rot[i]), $signed(got.rot[i]));
                            mismatch_count++;
                        end
                    for (int i = 0; i < 3; i++)
                        if (got.pos[i] !== want.pos[i]) begin
                            $error("pos_%s expected %0d got %0d",
                                   i == 0 ? "x" : (i == 1 ? "y" : "z"),
                                   $signed(want.pos[i]), $signed(got.pos[i]));
                            mismatch_count++;
                        end
                end
            end
            if ($urandom_range(0, 149) == 0) mon_burst <= ~mon_burst;
            if (mon_gap > 0) begin
                mon_gap       <= mon_gap - 1;
                pose_ch.ready <= 1'b0;
            end else begin
                pose_ch.ready <= 1'b1;
                mon_gap       <= pick_gap(mon_burst);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    function automatic joint_set_t all_joints(logic [15:0] a);
        joint_set_t js;
        js.drain = 1'b0;
        for (int j = 0; j < 7; j++) js.angle[j] = a;
        return js;
    endfunction

    initial begin
        joint_set_t js;
        logic [15:0] quarter_turns[6];
        quarter_turns = '{16'sd12868, 16'sd25736, -16'sd12868, -16'sd25736,
                          16'sd6434, 16'sd32767};
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        mismatch_count = 0;
        joint_ch.valid = 1'b0;
        joint_ch.joint1_angle = '0;
        joint_ch.joint2_angle = '0;
        joint_ch.joint3_angle = '0;
        joint_ch.joint4_angle = '0;
        joint_ch.joint5_angle = '0;
        joint_ch.joint6_angle = '0;
        joint_ch.joint7_angle = '0;
        pose_ch.ready = 1'b0;

        // Directed: home pose, range extremes (past half a turn either way),
        // alternating bit patterns, quadrant edges, one joint moved at a time.
        joint_sets_q.push_back(all_joints(16'h0000));
        joint_sets_q.push_back(all_joints(16'h7FFF));
        joint_sets_q.push_back(all_joints(16'h8000));
        joint_sets_q.push_back(all_joints(16'hFFFF));
        joint_sets_q.push_back(all_joints(16'h5555));
        joint_sets_q.push_back(all_joints(16'hAAAA));
        foreach (quarter_turns[q]) joint_sets_q.push_back(all_joints(quarter_turns[q]));
        for (int j = 0; j < 7; j++) begin
            js = all_joints(16'h0000);
            js.angle[j] = 16'sd12868;
            joint_sets_q.push_back(js);
        end
        // Stretched arm pose that pushes the translation outward.
        js = all_joints(16'h0000);
        js.angle[1] = 16'sd12868;
        js.angle[3] = -16'sd12868;
        joint_sets_q.push_back(js);

        // Random: mostly full-range angles, some within the physical limits.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            js.drain = (n == 400 || n == 900);
            for (int j = 0; j < 7; j++)
                js.angle[j] = ($urandom_range(0, 3) == 0) ?
                              16'($signed($urandom_range(0, 48000)) - 24000) :
                              16'($urandom);
            joint_sets_q.push_back(js);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every set to transfer and every pose to come back.
        while (joint_sets_q.size() != 0 || joint_ch.valid ||
               pending_poses_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("seven_joint_forward_kinematics_top test passed");
        else
            $display("seven_joint_forward_kinematics_top test failed");
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * 600000);
        $display("seven_joint_forward_kinematics_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/sjfk_pkg.sv
design/sjfk_joint_if.sv
design/sjfk_pose_if.sv
design/sjfk_sincos.sv
design/sjfk_compose.sv
design/seven_joint_forward_kinematics_top.sv
design/sjfk_checker.sv
tb/sv/tb_top.sv
